@@ rtl/skf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, widths, micro-op codes and the control store of the scalar
// Kalman filter sequencer.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int CovW    = 36;  // covariance and noise registers, 32 fraction bits
  localparam int DataW   = 32;  // Q16.16 sample and estimate
  localparam int PcW     = 3;
  localparam int CntW    = 5;
  localparam int DivSteps = 32; // shifted quotient steps after the integer step
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegProcessNoise     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMeasurementNoise = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInitialCov       = 2'd2;

  // datapath operations
  localparam logic [2:0] OpNop  = 3'd0;
  localparam logic [2:0] OpLoad = 3'd1;
  localparam logic [2:0] OpDiv0 = 3'd2;
  localparam logic [2:0] OpDiv  = 3'd3;
  localparam logic [2:0] OpMulK = 3'd4;
  localparam logic [2:0] OpCorr = 3'd5;
  localparam logic [2:0] OpCov  = 3'd6;
  localparam logic [2:0] OpOut  = 3'd7;

  // sequencing conditions
  localparam logic [1:0] CondNext    = 2'd0;
  localparam logic [1:0] CondWaitIn  = 2'd1;
  localparam logic [1:0] CondLoop    = 2'd2;
  localparam logic [1:0] CondWaitOut = 2'd3;

  typedef struct packed {
    logic [2:0]     op;
    logic [1:0]     cond;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_ready;
  } ctrl_t;

  // control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      3'd0:    w = '{op: OpNop,  cond: CondWaitIn,  target: 3'd0};
      3'd1:    w = '{op: OpLoad, cond: CondNext,    target: 3'd0};
      3'd2:    w = '{op: OpDiv0, cond: CondNext,    target: 3'd0};
      3'd3:    w = '{op: OpDiv,  cond: CondLoop,    target: 3'd3};
      3'd4:    w = '{op: OpMulK, cond: CondNext,    target: 3'd0};
      3'd5:    w = '{op: OpCorr, cond: CondNext,    target: 3'd0};
      3'd6:    w = '{op: OpCov,  cond: CondNext,    target: 3'd0};
      3'd7:    w = '{op: OpOut,  cond: CondWaitOut, target: 3'd0};
      default: w = '{op: OpNop,  cond: CondNext,    target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/skf_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_sequencer
// Program counter, loop counter and control store lookup. Issues one
// micro-op per cycle to the filter datapath.
// ----------------------------------------------------------------------------
module skf_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_free,
  output skf_pkg::ctrl_t ctrl
);

  logic [skf_pkg::PcW-1:0]  pc;
  logic [skf_pkg::PcW-1:0]  pc_next;
  logic [skf_pkg::CntW-1:0] cnt;
  skf_pkg::ucode_t          word;

  assign word          = skf_pkg::ucode_rom(pc);
  assign ctrl.op       = word.op;
  assign ctrl.in_ready = (word.cond == skf_pkg::CondWaitIn);

  always_comb begin
    case (word.cond)
      skf_pkg::CondNext:    pc_next = pc + 1'b1;
      skf_pkg::CondWaitIn:  pc_next = in_valid ? pc + 1'b1 : pc;
      skf_pkg::CondLoop:    pc_next = (cnt != '0) ? word.target : pc + 1'b1;
      skf_pkg::CondWaitOut: pc_next = out_free ? word.target : pc;
      default:              pc_next = pc + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      cnt <= '0;
    end else begin
      pc <= pc_next;
      if (word.op == skf_pkg::OpDiv0) begin
        cnt <= skf_pkg::CntW'(skf_pkg::DivSteps - 1);
      end else if (word.cond == skf_pkg::CondLoop && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ rtl/scalar_kalman_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter: covariance update, serial gain division,
// estimate correction and covariance scaling under microcode control.
// ----------------------------------------------------------------------------
// Each sample passes the load step, a 33-step restoring divider that forms the
//   gain, and the multiply, correction, covariance and output steps; a new
//   sample is taken only after the output step of the previous one.
// The next sample is taken while the previous estimate still waits.
// Reset: configuration returns to its reset values, current estimate and
//   covariance clear, no clearing pass.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [skf_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [skf_pkg::CovW-1:0]          cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [skf_pkg::DataW-1:0]  sample,
  output logic                              estimate_valid,
  input  logic                              estimate_stall,
  output logic signed [skf_pkg::DataW-1:0]  estimate
);

  localparam int CovW  = skf_pkg::CovW;
  localparam int DataW = skf_pkg::DataW;
  localparam int MagW  = DataW + 1;
  localparam int ProdW = DataW + MagW;

  skf_pkg::ctrl_t ctrl;

  logic [CovW-1:0]  process_noise;
  logic [CovW-1:0]  measurement_noise;
  logic [CovW-1:0]  initial_covariance;

  logic [DataW-1:0] sample_q;
  logic [DataW-1:0] current_estimate;
  logic [CovW-1:0]  error_covariance;
  logic             primed;

  logic [CovW:0]    den;
  logic [CovW+1:0]  rem;
  logic [MagW-1:0]  quot;
  logic [MagW-1:0]  mag;
  logic             err_neg;
  logic [ProdW-1:0] prod;

  logic             out_free;
  logic             take;

  assign cfg_ready    = 1'b1;
  assign sample_stall = !ctrl.in_ready;
  assign take         = sample_valid && ctrl.in_ready;
  assign out_free     = !estimate_valid || !estimate_stall;

  skf_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // load step: covariance grows by q with saturation, error magnitude
  logic [CovW-1:0]  p_base;
  logic [CovW:0]    p_sum;
  logic [CovW-1:0]  p_sat;
  logic [MagW-1:0]  err;

  assign p_base = primed ? error_covariance : initial_covariance;
  assign p_sum  = {1'b0, p_base} + {1'b0, process_noise};
  assign p_sat  = p_sum[CovW] ? {CovW{1'b1}} : p_sum[CovW-1:0];
  assign err    = {sample_q[DataW-1], sample_q}
                - {current_estimate[DataW-1], current_estimate};

  // divider step
  logic [CovW+1:0]  rem_sh;
  logic [CovW+1:0]  rem_in;
  logic             rem_ge;

  assign rem_sh = {rem[CovW:0], 1'b0};
  assign rem_in = (ctrl.op == skf_pkg::OpDiv0) ? rem : rem_sh;
  assign rem_ge = rem_in >= {1'b0, den};

  // gain, correction and covariance scaling
  logic [MagW-1:0]  gain;
  logic [MagW-1:0]  corr;
  logic [MagW-1:0]  est_sum;
  logic [MagW-1:0]  one_minus_k;
  logic [CovW-1:0]  m_hi;
  logic [CovW:0]    p_scaled;

  assign gain        = (den == '0) ? '0 : quot;
  assign corr        = quot[MagW-1] ? mag : prod[ProdW-1:DataW];
  assign est_sum     = err_neg ? {1'b0, current_estimate} - corr
                               : {1'b0, current_estimate} + corr;
  assign one_minus_k = {1'b1, {DataW{1'b0}}} - quot;
  assign m_hi        = CovW'(one_minus_k[DataW-1:0] * error_covariance[CovW-1:DataW]);
  assign p_scaled    = {1'b0, m_hi} + (CovW+1)'(prod[ProdW-1:DataW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= 36'd429497;
      measurement_noise  <= 36'd21474836;
      initial_covariance <= 36'd42949672960;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        skf_pkg::RegProcessNoise:     process_noise      <= cfg_data;
        skf_pkg::RegMeasurementNoise: measurement_noise  <= cfg_data;
        skf_pkg::RegInitialCov:       initial_covariance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_estimate <= '0;
      error_covariance <= '0;
      primed           <= 1'b0;
    end else begin
      case (ctrl.op)
        skf_pkg::OpLoad: begin
          primed           <= 1'b1;
          error_covariance <= p_sat;
        end
        skf_pkg::OpCorr: current_estimate <= est_sum[DataW-1:0];
        skf_pkg::OpCov: begin
          // gain of zero keeps p as it is
          if (one_minus_k[MagW-1]) begin
            error_covariance <= error_covariance;
          end else begin
            error_covariance <= p_scaled[CovW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_q <= sample;
    end
    case (ctrl.op)
      skf_pkg::OpLoad: begin
        den     <= {1'b0, p_sat} + {1'b0, measurement_noise};
        rem     <= {2'b00, p_sat};
        err_neg <= err[MagW-1];
        mag     <= err[MagW-1] ? -err : err;
      end
      skf_pkg::OpDiv0, skf_pkg::OpDiv: begin
        rem  <= rem_ge ? rem_in - {1'b0, den} : rem_in;
        quot <= {quot[MagW-2:0], rem_ge};
      end
      skf_pkg::OpMulK: begin
        quot <= gain;
        prod <= gain[DataW-1:0] * mag;
      end
      skf_pkg::OpCorr: begin
        prod <= one_minus_k[DataW-1:0] * {1'b0, error_covariance[DataW-1:0]};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_valid <= 1'b0;
    end else if (ctrl.op == skf_pkg::OpOut && out_free) begin
      estimate_valid <= 1'b1;
    end else if (!estimate_stall) begin
      estimate_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == skf_pkg::OpOut && out_free) begin
      estimate <= current_estimate;
    end
  end

  // a sample transfer starts the load step
  a_take_load: assert property (@(posedge clk) disable iff (rst)
    take |=> ctrl.op == skf_pkg::OpLoad)
    else $error("sample transfer not followed by load step");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == skf_pkg::OpCorr |-> !(quot[MagW-1] && quot[DataW-1:0] != '0))
    else $error("gain above one");

  // the output step with a free slot presents a result
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == skf_pkg::OpOut && out_free |=> estimate_valid)
    else $error("estimate not presented after output step");

  // no sample taken while a result is being computed
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    ctrl.op != skf_pkg::OpNop |-> sample_stall)
    else $error("sample ready while busy");

endmodule
